[rtl/dtf_pkg.sv]
// shared constants and types for the duplicate triangle filter
package dtf_pkg;

  localparam int CORNER_BITS   = 21;
  localparam int TABLE_ENTRIES = 4096;
  localparam int INDEX_BITS    = 21;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
  localparam int KEY_BITS      = 3 * INDEX_BITS;
  localparam int EPOCH_BITS    = 8;

  typedef logic [CORNER_BITS-1:0] corner_t;
  typedef logic [INDEX_BITS-1:0]  index_t;
  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [EPOCH_BITS-1:0]  epoch_t;

  // one table word: live only when valid and its epoch matches the current mesh
  typedef struct packed {
    logic   valid;
    epoch_t epoch;
    key_t   key;
  } entry_t;

  localparam int WORD_BITS = $bits(entry_t);

endpackage

[rtl/dtf_tri_if.sv]
// triangle input channel
interface dtf_tri_if;
  logic              valid;
  logic              ready;
  dtf_pkg::corner_t  corner_a;
  dtf_pkg::corner_t  corner_b;
  dtf_pkg::corner_t  corner_c;
  logic              start_mesh;

  modport source (output valid, corner_a, corner_b, corner_c, start_mesh, input ready);
  modport sink (input valid, corner_a, corner_b, corner_c, start_mesh, output ready);
endinterface

[rtl/dtf_res_if.sv]
// result output channel
interface dtf_res_if;
  logic valid;
  logic ready;
  logic keep;
  logic table_full;

  modport source (output valid, keep, table_full, input ready);
  modport sink (input valid, keep, table_full, output ready);
endinterface

[rtl/duplicate_triangle_filter_top.sv]
// duplicate triangle filter: sorted-key hash set with linear probing
//
// usage: in_ch carries one triangle (three vertex indices and start_mesh) per
// transfer; out_ch returns one result (keep, table_full) per triangle, in
// order. start_mesh empties the seen set before its own triangle.
// lookup: an item whose home slot is empty or holds its key finishes at its
// home slot; otherwise the probe walks the linear chain, and every probe is one
// read of the single-port key table. a full table is searched over
// TABLE_ENTRIES probes. in_ch takes no new triangle until the lookup finishes.
// the set is emptied by bumping an 8-bit mesh epoch stored with each entry.
// after reset, and on every 256th start_mesh when the epoch wraps, a clearing
// pass writes every word (all TABLE_ENTRIES of them); in_ch.ready is low
// meanwhile. a triangle that starts a wrap waits for its pass to end.
// a finished result sits in an output register, so the next triangle is taken
// while it waits; if out_ch stalls and the next result is ready, the lookup
// holds without writing until the register frees up.
// reset is synchronous and active high.
module duplicate_triangle_filter_top (
  input  logic      clk,
  input  logic      rst,
  dtf_tri_if.sink   in_ch,
  dtf_res_if.source out_ch
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  localparam dtf_pkg::slot_t LAST_SLOT = dtf_pkg::SLOT_BITS'(dtf_pkg::TABLE_ENTRIES - 1);

  // sort the masked corners so any rotation or reflection gives one key
  function automatic dtf_pkg::key_t make_key(input dtf_pkg::corner_t ca,
                                             input dtf_pkg::corner_t cb,
                                             input dtf_pkg::corner_t cc);
    dtf_pkg::index_t a;
    dtf_pkg::index_t b;
    dtf_pkg::index_t c;
    dtf_pkg::index_t t;
    a = ca[dtf_pkg::INDEX_BITS-1:0];
    b = cb[dtf_pkg::INDEX_BITS-1:0];
    c = cc[dtf_pkg::INDEX_BITS-1:0];
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (b > c) begin
      t = b; b = c; c = t;
    end
    if (a > b) begin
      t = a; a = b; b = t;
    end
    return {c, b, a};
  endfunction

  // xor fold of the key down to a slot number
  function automatic dtf_pkg::slot_t home_slot(input dtf_pkg::key_t k);
    dtf_pkg::slot_t h;
    h = '0;
    for (int i = 0; i < dtf_pkg::KEY_BITS; i++) begin
      h[(i * 7) % dtf_pkg::SLOT_BITS] ^= k[i];
    end
    return h;
  endfunction

  logic [1:0]       state;
  dtf_pkg::key_t    key;
  dtf_pkg::slot_t   slot;
  dtf_pkg::slot_t   probe_cnt;
  dtf_pkg::epoch_t  epoch;
  dtf_pkg::slot_t   clr_addr;
  logic             clr_resume;
  logic             out_valid;
  logic             keep;
  logic             table_full;

  logic                          ram_we;
  logic                          ram_re;
  dtf_pkg::slot_t                ram_addr;
  logic [dtf_pkg::WORD_BITS-1:0] ram_wdata;
  logic [dtf_pkg::WORD_BITS-1:0] ram_rdata;

  dtf_pkg::key_t   in_key;
  dtf_pkg::slot_t  in_slot;
  dtf_pkg::entry_t rd_word;
  dtf_pkg::entry_t wr_word;
  dtf_pkg::slot_t  slot_inc;
  logic            accept;
  logic            out_free;
  logic            live;
  logic            key_match;
  logic            last_probe;
  logic            finish;
  logic            commit;
  logic            step;

  dtf_ram #(
    .WIDTH (dtf_pkg::WORD_BITS),
    .DEPTH (dtf_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_key   = make_key(in_ch.corner_a, in_ch.corner_b, in_ch.corner_c);
  assign in_slot  = home_slot(in_key);
  assign in_ch.ready = (state == S_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  assign rd_word    = dtf_pkg::entry_t'(ram_rdata);
  assign live       = rd_word.valid && (rd_word.epoch == epoch);
  assign key_match  = live && (rd_word.key == key);
  assign last_probe = (probe_cnt == LAST_SLOT);
  assign slot_inc   = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  assign finish     = (state == S_CHECK) && (!live || key_match || last_probe);
  assign commit     = finish && out_free;
  // occupied by another key: move on down the chain
  assign step       = (state == S_CHECK) && live && !key_match && !last_probe;

  assign wr_word.valid = (state == S_CHECK);
  assign wr_word.epoch = epoch;
  assign wr_word.key   = key;

  // the insert write and the next item's first read fall in different cycles,
  // so no forwarding is needed
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = slot;
    ram_wdata = wr_word;
    case (state)
      S_IDLE: begin
        ram_re   = accept;
        ram_addr = in_slot;
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_CHECK: begin
        if (commit && !live) begin
          ram_we = 1'b1;
        end else if (step) begin
          ram_re   = 1'b1;
          ram_addr = slot_inc;
        end
      end
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_resume <= 1'b0;
      epoch      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            key       <= in_key;
            slot      <= in_slot;
            probe_cnt <= '0;
            if (in_ch.start_mesh) begin
              epoch <= epoch + 1'b1;
            end
            // epoch wraps: old words could alias, wipe the table first
            if (in_ch.start_mesh && (epoch == '1)) begin
              state      <= S_CLEAR;
              clr_addr   <= '0;
              clr_resume <= 1'b1;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (commit) begin
            state <= S_IDLE;
          end else if (step) begin
            slot      <= slot_inc;
            probe_cnt <= probe_cnt + 1'b1;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_SLOT) begin
            state <= clr_resume ? S_READ : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      keep       <= !key_match;
      table_full <= live && !key_match;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.keep       = keep;
  assign out_ch.table_full = table_full;

`ifndef SYNTH
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CHECK) || (state == S_CLEAR))
    else $error("accepted triangle did not start a lookup");

  a_dup_not_full: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.keep) |-> !out_ch.table_full)
    else $error("duplicate reported as table full");

  a_commit_frees_input: assert property (@(posedge clk) disable iff (rst)
    commit |=> in_ch.ready && out_ch.valid)
    else $error("finished lookup did not deliver result and reopen input");

  a_step_advances: assert property (@(posedge clk) disable iff (rst)
    step |=> (state == S_CHECK) && (probe_cnt == $past(probe_cnt) + 1'b1))
    else $error("probe chain did not advance");
`endif

endmodule

[rtl/dtf_ram.sv]
// generic single-port synchronous ram with registered read
module dtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
